// ===== design/ler_pkg.sv =====
// Package with shared constants and types for the largest empty rectangle core.
package ler_pkg;
  localparam int MaxSide = 128;
  localparam int IdxW = $clog2(MaxSide);
  localparam int CntW = $clog2(MaxSide + 1);
  localparam int StkW = IdxW + CntW;
  localparam int ProdW = 2 * CntW;
  localparam int AreaW = 15;
  localparam logic [7:0] SideReset = 8'd128;
  localparam logic OpAdd = 1'b0;
  localparam logic OpFinish = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_ROW_RD,
    ST_HGT_RD,
    ST_HGT,
    ST_POP,
    ST_POP_WAIT,
    ST_ROW_NEXT,
    ST_OUT
  } state_t;
endpackage

// ===== design/largest_empty_rectangle_core.sv =====
// Top level of the largest empty rectangle core.
// Channel | Role   | Fields, lowest bit first
// in_     | slave  | tdata[0]=op, [8:1]=top_row, [16:9]=left_col, [24:17]=bottom_row,
//         |        | [32:25]=right_col
// out_    | master | tdata[14:0]=largest_area
// cfg_    | slave  | data[7:0]=grid_side
// An add transaction reads and rewrites each stored grid row it covers.
// A finish transaction scans each grid row up to the configured side,
// then loads the result register and clears the whole grid.
// A finish transaction waits before the clear only while the previous result is unread.
// After reset a clearing pass over the whole grid runs before in_tready rises.
// Configuration is taken only while the core is idle.
module largest_empty_rectangle_core
  import ler_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // op, top_row, left_col, bottom_row, right_col
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // largest_area
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  logic [MaxSide-1:0] grid_mem [MaxSide];
  logic [CntW-1:0]    hgt_mem [MaxSide];
  logic [StkW-1:0]    stk_mem [MaxSide];

  state_t state_r, state_nxt;
  logic [7:0] side_r;
  logic [CntW-1:0] side_c;
  logic [CntW-1:0] row_r, row_nxt, col_r, col_nxt, top_r, top_nxt, rend_r, rend_nxt;
  logic [MaxSide-1:0] mask_r, mask_nxt;
  logic [MaxSide-1:0] row_q_r;
  logic [CntW-1:0] h_q_r;
  logic [StkW-1:0] s_q_r;
  logic [CntW-1:0] tos_h_r, tos_h_nxt, cur_h_r, cur_h_nxt;
  logic [IdxW-1:0] tos_start_r, tos_start_nxt, start_r, start_nxt;
  logic [AreaW-1:0] best_r, best_nxt, res_r, res_nxt;
  logic res_v_r, res_v_nxt;
  logic [ProdW-1:0] area_w;

  logic g_we;
  logic [IdxW-1:0] g_addr, g_waddr;
  logic [MaxSide-1:0] g_wd;
  logic h_we;
  logic [IdxW-1:0] h_addr;
  logic [CntW-1:0] h_wd;
  logic s_we;
  logic [IdxW-1:0] s_waddr, s_raddr;
  logic [StkW-1:0] s_wd;

  logic [7:0] f_top, f_left, f_bot, f_right;
  logic [7:0] rs, cs, re, ce;

  assign f_top   = in_tdata[8:1];
  assign f_left  = in_tdata[16:9];
  assign f_bot   = in_tdata[24:17];
  assign f_right = in_tdata[32:25];
  assign side_c = (side_r > 8'(MaxSide)) ? CntW'(MaxSide) : CntW'(side_r);
  assign rs = (f_top == 8'd0) ? 8'd0 : f_top - 8'd1;
  assign cs = (f_left == 8'd0) ? 8'd0 : f_left - 8'd1;
  assign re = (f_bot > 8'(MaxSide)) ? 8'(MaxSide) : f_bot;
  assign ce = (f_right > 8'(MaxSide)) ? 8'(MaxSide) : f_right;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_tvalid = res_v_r;
  assign out_tdata = {1'b0, res_r};

  // The popped bar spans from its start column up to the current column.
  assign area_w = ProdW'(tos_h_r) * ProdW'(col_r - CntW'(tos_start_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SideReset;
    end else if (cfg_valid && cfg_ready) begin
      side_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (g_we) grid_mem[g_waddr] <= g_wd;
    row_q_r <= grid_mem[g_addr];
    if (h_we) hgt_mem[h_addr] <= h_wd;
    h_q_r <= hgt_mem[h_addr];
    if (s_we) stk_mem[s_waddr] <= s_wd;
    s_q_r <= stk_mem[s_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r; col_nxt = col_r; top_nxt = top_r; rend_nxt = rend_r;
    mask_nxt = mask_r; best_nxt = best_r; cur_h_nxt = cur_h_r; start_nxt = start_r;
    tos_h_nxt = tos_h_r; tos_start_nxt = tos_start_r;
    res_nxt = res_r;
    res_v_nxt = (out_tvalid && out_tready) ? 1'b0 : res_v_r;
    g_we = 1'b0; g_addr = row_r[IdxW-1:0]; g_waddr = row_r[IdxW-1:0]; g_wd = '0;
    h_we = 1'b0; h_addr = col_r[IdxW-1:0]; h_wd = '0;
    s_we = 1'b0; s_waddr = '0; s_raddr = '0; s_wd = '0;
    unique case (state_r)
      ST_CLEAR: begin
        g_we = 1'b1;
        if (row_r == CntW'(MaxSide - 1)) begin
          state_nxt = ST_IDLE;
        end
        row_nxt = row_r + CntW'(1);
      end
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_tdata[0] == OpAdd) begin
            if (f_bot != 8'd0 && f_right != 8'd0 && f_top <= f_bot && f_left <= f_right
                && rs < re && cs < ce) begin
              for (int i = 0; i < MaxSide; i++)
                mask_nxt[i] = (8'(i) >= cs) && (8'(i) < ce);
              row_nxt = CntW'(rs);
              rend_nxt = CntW'(re);
              state_nxt = ST_MARK_RD;
            end
          end else begin
            best_nxt = '0;
            row_nxt = '0;
            state_nxt = (side_c == '0) ? ST_OUT : ST_ROW_RD;
          end
        end
      end
      ST_MARK_RD: begin
        state_nxt = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        g_we = 1'b1;
        g_wd = row_q_r | mask_r;
        if (row_r + CntW'(1) >= rend_r) begin
          state_nxt = ST_IDLE;
        end else begin
          row_nxt = row_r + CntW'(1);
          state_nxt = ST_MARK_RD;
        end
      end
      ST_ROW_RD: begin
        col_nxt = '0;
        top_nxt = '0;
        state_nxt = ST_HGT_RD;
      end
      ST_HGT_RD: begin
        state_nxt = ST_HGT;
      end
      ST_HGT: begin
        if (col_r < side_c) begin
          h_wd = row_q_r[col_r[IdxW-1:0]] ? CntW'(0) :
                 ((row_r == '0) ? CntW'(1) : h_q_r + CntW'(1));
          h_we = 1'b1;
          cur_h_nxt = h_wd;
        end else begin
          cur_h_nxt = '0;
        end
        start_nxt = col_r[IdxW-1:0];
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (top_r != '0 && tos_h_r >= cur_h_r) begin
          best_nxt = (AreaW'(area_w) > best_r) ? AreaW'(area_w) : best_r;
          start_nxt = tos_start_r;
          top_nxt = top_r - CntW'(1);
          if (top_r > CntW'(1)) begin
            s_raddr = IdxW'(top_r - CntW'(2));
            state_nxt = ST_POP_WAIT;
          end
        end else if (col_r < side_c) begin
          if (top_r != '0) begin
            s_we = 1'b1;
            s_waddr = IdxW'(top_r - CntW'(1));
            s_wd = {tos_start_r, tos_h_r};
          end
          tos_start_nxt = start_r;
          tos_h_nxt = cur_h_r;
          top_nxt = top_r + CntW'(1);
          col_nxt = col_r + CntW'(1);
          state_nxt = ST_HGT_RD;
        end else begin
          state_nxt = ST_ROW_NEXT;
        end
      end
      ST_POP_WAIT: begin
        {tos_start_nxt, tos_h_nxt} = s_q_r;
        state_nxt = ST_POP;
      end
      ST_ROW_NEXT: begin
        if (row_r + CntW'(1) >= side_c) begin
          state_nxt = ST_OUT;
        end else begin
          row_nxt = row_r + CntW'(1);
          state_nxt = ST_ROW_RD;
        end
      end
      ST_OUT: begin
        if (!res_v_r || out_tready) begin
          res_nxt = best_r;
          res_v_nxt = 1'b1;
          row_nxt = '0;
          state_nxt = ST_CLEAR;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      row_r <= '0;
      col_r <= '0;
      top_r <= '0;
      best_r <= '0;
      res_r <= '0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      top_r <= top_nxt;
      best_r <= best_nxt;
      res_r <= res_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rend_r <= rend_nxt;
    mask_r <= mask_nxt;
    cur_h_r <= cur_h_nxt;
    start_r <= start_nxt;
    tos_h_r <= tos_h_nxt;
    tos_start_r <= tos_start_nxt;
  end
endmodule

// ===== design/ler_checker.sv =====
// Port-level checker for the largest empty rectangle core, with its bind.
module ler_checker
  import ler_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out held");
  a_area_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= 16'(MaxSide * MaxSide)) else $error("area range");
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown(out_tdata)) else $error("area unknown");
  a_reset_quiet: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_tready && !out_tvalid) else $error("active after reset");
endmodule

bind largest_empty_rectangle_core ler_checker u_ler_checker (.*);
